/* rtl/core/binary_to_packed_bcd_core_defines.svh */
// Assertion macros shared by the binary to packed BCD checker.
`ifndef BINARY_TO_PACKED_BCD_CORE_DEFINES_SVH
`define BINARY_TO_PACKED_BCD_CORE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define BPBCD_ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bpbcd: invariant violated");

// Consequent must hold in the cycle after the antecedent.
`define BPBCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bpbcd: next-cycle check violated");

`endif

/* rtl/core/bpbcd_pkg.sv */
// Types, constants and conversion functions for the binary to packed BCD core.
package bpbcd_pkg;

  // Field widths
  localparam int VALUE_W = 64;
  localparam int CODE_W  = 3;
  localparam int BCD_W   = 64;
  localparam int DIGITS  = BCD_W / 4;

  // Largest accepted value is 10^16 - 1, which fits in 54 bits
  localparam int BIN_W           = 54;
  localparam int STEPS_PER_STAGE = 3;
  localparam int NUM_STAGES      = BIN_W / STEPS_PER_STAGE;

  // Size codes
  localparam logic [CODE_W-1:0] SIZE_2  = 3'd0;
  localparam logic [CODE_W-1:0] SIZE_4  = 3'd1;
  localparam logic [CODE_W-1:0] SIZE_6  = 3'd2;
  localparam logic [CODE_W-1:0] SIZE_8  = 3'd3;
  localparam logic [CODE_W-1:0] SIZE_12 = 3'd4;
  localparam logic [CODE_W-1:0] SIZE_16 = 3'd5;

  // Largest value per digit count
  localparam logic [VALUE_W-1:0] MAX_2  = 64'd99;
  localparam logic [VALUE_W-1:0] MAX_4  = 64'd9999;
  localparam logic [VALUE_W-1:0] MAX_6  = 64'd999999;
  localparam logic [VALUE_W-1:0] MAX_8  = 64'd99999999;
  localparam logic [VALUE_W-1:0] MAX_12 = 64'd999999999999;
  localparam logic [VALUE_W-1:0] MAX_16 = 64'd9999999999999999;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [CODE_W-1:0]  size_code;
  } in_t;

  typedef struct packed {
    logic [BCD_W-1:0] bcd_digits;
    logic             ok;
  } out_t;

  // One pipeline stage: digit accumulator, remaining binary bits, fit flag
  typedef struct packed {
    logic [BCD_W-1:0] bcd;
    logic [BIN_W-1:0] bin;
    logic             ok;
  } stage_t;

  // True when value fits the selected digit count; unused codes never fit
  function automatic logic code_fits(input logic [VALUE_W-1:0] value,
                                     input logic [CODE_W-1:0]  code);
    logic fits;
    unique case (code)
      SIZE_2:  fits = (value <= MAX_2);
      SIZE_4:  fits = (value <= MAX_4);
      SIZE_6:  fits = (value <= MAX_6);
      SIZE_8:  fits = (value <= MAX_8);
      SIZE_12: fits = (value <= MAX_12);
      SIZE_16: fits = (value <= MAX_16);
      default: fits = 1'b0;
    endcase
    return fits;
  endfunction

  // One shift-add-3 step: correct every digit, then shift in the next bit
  function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                   input logic             bin_bit);
    logic [BCD_W-1:0] adj;
    logic [3:0]       nib;
    for (int d = 0; d < DIGITS; d++) begin
      nib          = bcd[4*d +: 4];
      adj[4*d +: 4] = (nib >= 4'd5) ? (nib + 4'd3) : nib;
    end
    return {adj[BCD_W-2:0], bin_bit};
  endfunction

  // A stage's worth of steps, MSB of the binary part first
  function automatic stage_t dabble_stage(input stage_t s);
    stage_t t;
    t = s;
    for (int k = 0; k < STEPS_PER_STAGE; k++) begin
      t.bcd = dabble_step(t.bcd, t.bin[BIN_W-1]);
      t.bin = {t.bin[BIN_W-2:0], 1'b0};
    end
    return t;
  endfunction

endpackage

/* rtl/core/binary_to_packed_bcd_core.sv */
// Binary to packed BCD converter: range check stage and shift-add-3 pipeline.
// Takes one request per cycle unless a result waits untaken at the output.
// A first register stage checks the value against the selected digit count,
// then 18 stages each run three of the 54 shift-add-3 steps over all 16
// digits. A value that does not fit, or an unused size code, is zeroed at
// entry, so it leaves with ok low and zero digits. When the result is not
// taken the whole pipeline holds in place.
module binary_to_packed_bcd_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  bpbcd_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output bpbcd_pkg::out_t out_data
);

  localparam int NS = bpbcd_pkg::NUM_STAGES;

  bpbcd_pkg::stage_t pipe_r [0:NS];
  logic [NS:0]       vld_r;
  bpbcd_pkg::stage_t pipe0_nxt;
  logic              adv;
  logic              fits;

  // Global advance: move when the output slot is empty or being taken
  assign adv      = !vld_r[NS] || out_ready;
  assign in_ready = adv;

  // Entry: range check, values that do not fit or carry an unused code enter as zero
  always_comb begin
    fits          = bpbcd_pkg::code_fits(in_data.value, in_data.size_code);
    pipe0_nxt.bcd = '0;
    pipe0_nxt.bin = fits ? in_data.value[bpbcd_pkg::BIN_W-1:0] : '0;
    pipe0_nxt.ok  = fits;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NS-1:0], in_valid};
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      pipe_r[0] <= pipe0_nxt;
      for (int i = 1; i <= NS; i++) begin
        pipe_r[i] <= bpbcd_pkg::dabble_stage(pipe_r[i-1]);
      end
    end
  end

  // Result
  assign out_valid           = vld_r[NS];
  assign out_data.bcd_digits = pipe_r[NS].bcd;
  assign out_data.ok         = pipe_r[NS].ok;

endmodule

/* rtl/core/bpbcd_checker.sv */
// Port-level assertions for the binary to packed BCD core, with its bind.
`include "binary_to_packed_bcd_core_defines.svh"

module bpbcd_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input bpbcd_pkg::in_t  in_data,
  input logic            out_valid,
  input logic            out_ready,
  input bpbcd_pkg::out_t out_data
);

  logic res_ovf;
  logic res_good;

  // Result classes
  assign res_ovf  = out_valid && !out_data.ok;
  assign res_good = out_valid && out_data.ok;

  // Every nibble is a decimal digit
  function automatic logic all_decimal(input logic [bpbcd_pkg::BCD_W-1:0] bcd);
    logic good;
    good = 1'b1;
    for (int d = 0; d < bpbcd_pkg::DIGITS; d++) begin
      if (bcd[4*d +: 4] > 4'd9) good = 1'b0;
    end
    return good;
  endfunction

  // Overflow results carry no digits
  `BPBCD_ASSERT_ALWAYS(a_ovf_zero, clk, rst_n, res_ovf |-> (out_data.bcd_digits == '0))

  // Good results are proper BCD
  `BPBCD_ASSERT_ALWAYS(a_digits_bcd, clk, rst_n, res_good |-> all_decimal(out_data.bcd_digits))

  // Input side stalls exactly when a result is held
  `BPBCD_ASSERT_ALWAYS(a_ready_link, clk, rst_n, in_ready == (!out_valid || out_ready))

  // A stalled result holds
  `BPBCD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

  // A waiting request holds
  `BPBCD_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready, in_valid && $stable(in_data))

endmodule

bind binary_to_packed_bcd_core bpbcd_checker u_bpbcd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* sim/binary_to_packed_bcd_core_tb.sv */
// Testbench for the binary to packed BCD core: random and directed requests, scoreboard check.
`timescale 1ns / 100ps

module binary_to_packed_bcd_core_tb;

  localparam int          ITEMS_RANDOM  = 750;
  localparam int          STEADY_FIRST  = 300;
  localparam int          STEADY_LAST   = 449;
  localparam int          DRAIN_AT      = 550;
  localparam int          TAIL_CYCLES   = 60;
  localparam int          CYCLE_LIMIT   = 200000;
  localparam int          GAP_PERCENT   = 16;
  localparam logic [2:0]  SIZE_UNUSED_A = 3'd6;
  localparam logic [2:0]  SIZE_UNUSED_B = 3'd7;

  // Keeps predicted conversions in order and compares them with results
  class bcd_checker;
    bpbcd_pkg::out_t expected_bcd[$];
    int              errors;

    function new();
      errors = 0;
    endfunction

    // Digit count and largest fitting value for a size code; unused codes give zero digits
    static function void size_info(input logic [2:0] code, output int ndig,
                                   output logic [63:0] limit);
      ndig  = 0;
      limit = '0;
      case (code)
        bpbcd_pkg::SIZE_2: begin
          ndig  = 2;
          limit = bpbcd_pkg::MAX_2;
        end
        bpbcd_pkg::SIZE_4: begin
          ndig  = 4;
          limit = bpbcd_pkg::MAX_4;
        end
        bpbcd_pkg::SIZE_6: begin
          ndig  = 6;
          limit = bpbcd_pkg::MAX_6;
        end
        bpbcd_pkg::SIZE_8: begin
          ndig  = 8;
          limit = bpbcd_pkg::MAX_8;
        end
        bpbcd_pkg::SIZE_12: begin
          ndig  = 12;
          limit = bpbcd_pkg::MAX_12;
        end
        bpbcd_pkg::SIZE_16: begin
          ndig  = 16;
          limit = bpbcd_pkg::MAX_16;
        end
        default: begin
          ndig  = 0;
          limit = '0;
        end
      endcase
    endfunction

    // Decimal digits by repeated division; overflow or unused code gives zero, ok low
    function bpbcd_pkg::out_t convert_to_bcd(input bpbcd_pkg::in_t req);
      bpbcd_pkg::out_t res;
      int              ndig;
      logic [63:0]     limit;
      logic [63:0]     rest;
      res = '0;
      size_info(req.size_code, ndig, limit);
      if (ndig != 0 && req.value <= limit) begin
        rest = req.value;
        for (int d = 0; d < ndig; d++) begin
          res.bcd_digits[4*d +: 4] = 4'(rest % 64'd10);
          rest = rest / 64'd10;
        end
        res.ok = 1'b1;
      end
      return res;
    endfunction

    function void note_request(input bpbcd_pkg::in_t req);
      expected_bcd.push_back(convert_to_bcd(req));
    endfunction

    function void check_result(input bpbcd_pkg::out_t got);
      bpbcd_pkg::out_t want;
      if (expected_bcd.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: digits=%h ok=%b", got.bcd_digits, got.ok);
        return;
      end
      want = expected_bcd.pop_front();
      if (got.bcd_digits !== want.bcd_digits || got.ok !== want.ok) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected digits=%h ok=%b, got digits=%h ok=%b",
                   want.bcd_digits, want.ok, got.bcd_digits, got.ok);
      end
    endfunction

    function int pending();
      return expected_bcd.size();
    endfunction
  endclass

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  logic            in_ready;
  bpbcd_pkg::in_t  in_data   = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  bpbcd_pkg::out_t out_data;

  bit         steady = 1'b0;
  int         cycles = 0;
  bcd_checker sb     = new();

  binary_to_packed_bcd_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: random back-pressure outside the steady stretch, check every accepted result
  always @(posedge clk) begin
    out_ready <= steady ? 1'b1 : ($urandom_range(99) >= GAP_PERCENT);
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_data);
  end

  // Present one request, with an optional idle gap first, and hold it until taken
  task automatic send_request(input bpbcd_pkg::in_t req);
    while (!steady && $urandom_range(99) < GAP_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(req);
  endtask

  function automatic bpbcd_pkg::in_t make_request(input logic [63:0] value,
                                                  input logic [2:0]  code);
    bpbcd_pkg::in_t req;
    req.value     = value;
    req.size_code = code;
    return req;
  endfunction

  // Mostly fitting values of varied magnitude, plus boundaries, overflows and unused codes
  function automatic bpbcd_pkg::in_t random_request();
    int          kind;
    int          ndig;
    logic [2:0]  code;
    logic [63:0] limit;
    logic [63:0] raw;
    kind = $urandom_range(99);
    code = 3'($urandom_range(bpbcd_pkg::SIZE_16, bpbcd_pkg::SIZE_2));
    raw  = {$urandom, $urandom};
    bcd_checker::size_info(code, ndig, limit);
    if (kind < 55)
      return make_request((raw >> $urandom_range(63)) % (limit + 64'd1), code);
    else if (kind < 70)
      return make_request(limit - 64'd3 + 64'($urandom_range(6)), code);
    else if (kind < 90)
      return make_request(raw >> $urandom_range(10), code);
    else
      return make_request(raw, $urandom_range(1) ? SIZE_UNUSED_A : SIZE_UNUSED_B);
  endfunction

  initial begin
    int          ndig;
    logic [63:0] limit;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero, the largest fit and the first overflow for every digit count
    for (logic [3:0] c = {1'b0, bpbcd_pkg::SIZE_2}; c <= bpbcd_pkg::SIZE_16; c++) begin
      bcd_checker::size_info(c[2:0], ndig, limit);
      send_request(make_request(64'd0, c[2:0]));
      send_request(make_request(limit, c[2:0]));
      send_request(make_request(limit + 64'd1, c[2:0]));
    end
    send_request(make_request('1, bpbcd_pkg::SIZE_16));
    send_request(make_request(64'd5, SIZE_UNUSED_A));
    send_request(make_request('1, SIZE_UNUSED_B));
    send_request(make_request(64'd0, SIZE_UNUSED_B));

    // Random part, with a gap-free stretch and one full drain
    for (int i = 0; i < ITEMS_RANDOM; i++) begin
      steady = (i >= STEADY_FIRST && i <= STEADY_LAST);
      if (i == DRAIN_AT) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
      end
      send_request(random_request());
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/bpbcd_pkg.sv
rtl/core/binary_to_packed_bcd_core.sv
rtl/core/bpbcd_checker.sv
sim/binary_to_packed_bcd_core_tb.sv
